FILE: hw/rtl/stable_sorted_priority_queue_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stable sorted priority queue
// Shared immediate-style wrappers around clocked concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SSPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sspq_pkg.sv
// ---------------------------------------------------------------------------
// sspq_pkg
// Types and constants shared by the priority queue controller and datapath.
// ---------------------------------------------------------------------------
package sspq_pkg;

  localparam int DEFAULT_DEPTH   = 16;
  localparam int VALUE_WIDTH     = 16;
  localparam int PRIORITY_WIDTH  = 8;
  localparam int ELEMENT_COUNT_W = 5;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic [VALUE_WIDTH-1:0]    item_value;
    logic [PRIORITY_WIDTH-1:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]     out_value;
    logic                       out_valid;
    status_t                    status;
    logic [ELEMENT_COUNT_W-1:0] element_count;
  } out_item_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

FILE: hw/rtl/sspq_ctrl.sv
// ---------------------------------------------------------------------------
// sspq_ctrl
// Controller: takes one item, schedules its update, and owns result valid.
// ---------------------------------------------------------------------------
`include "stable_sorted_priority_queue_defines.svh"

module sspq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output sspq_pkg::dp_cmd_t cmd
);

  sspq_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sspq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result register is free when empty or drained at this edge.
  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      sspq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sspq_pkg::ST_EXEC;
        end
      end
      sspq_pkg::ST_EXEC: begin
        if (res_free) begin
          cmd.execute = 1'b1;
          state_nxt   = sspq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sspq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `SSPQ_ASSERT_NOW(a_exec_needs_free_result, cmd.execute, res_free, "result overwritten")
  `SSPQ_ASSERT_NEXT(a_one_item_in_flight, in_valid && in_ready, !in_ready, "second item taken")
  `SSPQ_ASSERT_NEXT(a_exec_shows_result, cmd.execute, out_valid_r, "result not presented")

endmodule

FILE: hw/rtl/sspq_dpath.sv
// ---------------------------------------------------------------------------
// sspq_dpath
// Datapath: request register, sorted cell chain, fill count, result register.
// ---------------------------------------------------------------------------
`include "stable_sorted_priority_queue_defines.svh"

module sspq_dpath #(
  parameter int DEPTH = sspq_pkg::DEFAULT_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sspq_pkg::dp_cmd_t   cmd,
  input  sspq_pkg::in_item_t  in_data,
  output sspq_pkg::out_item_t out_data
);

  localparam int COUNT_W = $clog2(DEPTH + 1);

  sspq_pkg::in_item_t  req_r;
  sspq_pkg::out_item_t res_r, res_nxt;

  logic [sspq_pkg::VALUE_WIDTH-1:0]    val_r   [DEPTH];
  logic [sspq_pkg::VALUE_WIDTH-1:0]    val_nxt [DEPTH];
  logic [sspq_pkg::PRIORITY_WIDTH-1:0] pri_r   [DEPTH];
  logic [sspq_pkg::PRIORITY_WIDTH-1:0] pri_nxt [DEPTH];
  logic [COUNT_W-1:0]                  count_r, count_nxt;

  logic [DEPTH-1:0] ge;
  logic             full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    res_r <= res_nxt;
    for (int i = 0; i < DEPTH; i++) begin
      val_r[i] <= val_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
  end

  assign full  = (count_r == COUNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Each occupied cell whose priority is at least the new one keeps its
  // entry; the chain is sorted, so these cells form a prefix.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (COUNT_W'(i) < count_r) && (pri_r[i] >= req_r.item_priority);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
    end
    count_nxt = count_r;
    res_nxt   = res_r;

    if (cmd.execute) begin
      res_nxt.out_value = '0;
      res_nxt.out_valid = 1'b0;
      res_nxt.status    = sspq_pkg::STATUS_OK;
      if (req_r.opcode == sspq_pkg::OP_ENQUEUE) begin
        if (full) begin
          res_nxt.status = sspq_pkg::STATUS_FULL;
        end else begin
          if (!ge[0]) begin
            val_nxt[0] = req_r.item_value;
            pri_nxt[0] = req_r.item_priority;
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (!ge[i]) begin
              if (ge[i-1]) begin
                val_nxt[i] = req_r.item_value;
                pri_nxt[i] = req_r.item_priority;
              end else begin
                val_nxt[i] = val_r[i-1];
                pri_nxt[i] = pri_r[i-1];
              end
            end
          end
          count_nxt = count_r + COUNT_W'(1);
        end
      end else begin
        if (empty) begin
          res_nxt.status = sspq_pkg::STATUS_EMPTY;
        end else begin
          res_nxt.out_value = val_r[0];
          res_nxt.out_valid = 1'b1;
          for (int i = 0; i < DEPTH - 1; i++) begin
            val_nxt[i] = val_r[i+1];
            pri_nxt[i] = pri_r[i+1];
          end
          count_nxt = count_r - COUNT_W'(1);
        end
      end
      res_nxt.element_count = sspq_pkg::ELEMENT_COUNT_W'(count_nxt);
    end
  end

  assign out_data = res_r;

  `SSPQ_ASSERT_NOW(a_count_in_range, 1'b1, count_r <= COUNT_W'(DEPTH), "fill count overflow")
  `SSPQ_ASSERT_NEXT(a_dequeue_count, cmd.execute && !empty && req_r.opcode == sspq_pkg::OP_DEQUEUE, count_r == $past(count_r) - COUNT_W'(1), "dequeue count slip")

endmodule

FILE: hw/rtl/stable_sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue, highest priority first, arrival order among equals.
// ---------------------------------------------------------------------------
// Each item is an enqueue or a dequeue and produces exactly one result item
// carrying the removed value (dequeue), a status (ok, full, empty) and the
// number of entries held afterwards. The request register first latches an
// item; then the cell chain inserts or shifts all entries in parallel and
// loads the result register. The block then takes its next item; while a
// result waits in the output register a new item is still latched, and its
// update waits only until that register is taken.
module stable_sorted_priority_queue #(
  parameter int DEPTH = sspq_pkg::DEFAULT_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sspq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sspq_pkg::out_item_t out_data
);

  sspq_pkg::dp_cmd_t cmd;

  sspq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sspq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the stable sorted priority queue. Enqueue and
// dequeue items are sent over the input channel. A shadow queue, kept in
// priority order with arrival order among equals, predicts every result.
// Each result is compared field by field with the oldest prediction. The
// run covers directed corner cases, a long receiver hold-off, and random
// fill and drain bursts under three idling mixes.
// ---------------------------------------------------------------------------
module tb;

  localparam int QDEPTH      = sspq_pkg::DEFAULT_DEPTH;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 20;

  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIX
  } burst_t;

  typedef enum int {
    PRI_ANY,
    PRI_NARROW,
    PRI_EXTREMES,
    PRI_SAME
  } pri_style_t;

  logic                rst_n;
  logic                clk = 1'b0;
  logic                in_valid;
  logic                in_ready;
  sspq_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  sspq_pkg::out_item_t out_data;

  // Shadow copy of the queue contents, head at slot 0.
  logic [sspq_pkg::VALUE_WIDTH-1:0]    shadow_value [QDEPTH];
  logic [sspq_pkg::PRIORITY_WIDTH-1:0] shadow_prio  [QDEPTH];
  int                                  shadow_fill;

  sspq_pkg::out_item_t pending_results[$];

  int error_count;
  int items_sent;
  int results_checked;
  int full_hits;
  int empty_hits;
  int values_dequeued;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_len;
  int quiet_cycles;

  stable_sorted_priority_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Applies one operation to the shadow queue and returns the result it causes.
  function automatic sspq_pkg::out_item_t apply_queue_op(input sspq_pkg::in_item_t it);
    sspq_pkg::out_item_t r;
    int                  pos;
    r = '0;
    r.status = sspq_pkg::STATUS_OK;
    if (it.opcode == sspq_pkg::OP_ENQUEUE) begin
      if (shadow_fill >= QDEPTH) begin
        r.status = sspq_pkg::STATUS_FULL;
        full_hits++;
      end else begin
        // The new entry goes behind every entry of equal or higher priority.
        pos = 0;
        while (pos < shadow_fill && shadow_prio[pos] >= it.item_priority) pos++;
        for (int k = shadow_fill; k > pos; k--) begin
          shadow_value[k] = shadow_value[k-1];
          shadow_prio[k]  = shadow_prio[k-1];
        end
        shadow_value[pos] = it.item_value;
        shadow_prio[pos]  = it.item_priority;
        shadow_fill++;
      end
    end else if (shadow_fill == 0) begin
      r.status = sspq_pkg::STATUS_EMPTY;
      empty_hits++;
    end else begin
      r.out_value = shadow_value[0];
      r.out_valid = 1'b1;
      for (int k = 1; k < shadow_fill; k++) begin
        shadow_value[k-1] = shadow_value[k];
        shadow_prio[k-1]  = shadow_prio[k];
      end
      shadow_fill--;
      values_dequeued++;
    end
    r.element_count = sspq_pkg::ELEMENT_COUNT_W'(shadow_fill);
    return r;
  endfunction

  function automatic sspq_pkg::in_item_t make_enqueue(
      input logic [sspq_pkg::VALUE_WIDTH-1:0]    v,
      input logic [sspq_pkg::PRIORITY_WIDTH-1:0] p);
    sspq_pkg::in_item_t it;
    it.opcode        = sspq_pkg::OP_ENQUEUE;
    it.item_value    = v;
    it.item_priority = p;
    return it;
  endfunction

  function automatic sspq_pkg::in_item_t make_dequeue(
      input logic [sspq_pkg::VALUE_WIDTH-1:0]    v,
      input logic [sspq_pkg::PRIORITY_WIDTH-1:0] p);
    sspq_pkg::in_item_t it;
    it.opcode        = sspq_pkg::OP_DEQUEUE;
    it.item_value    = v;
    it.item_priority = p;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d, t=%0t)",
             what, got, want, results_checked, $realtime);
    error_count++;
  endtask

  // Offers one item, possibly after a random gap, and records its prediction
  // at the edge where it is taken.
  task automatic send_item(input sspq_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_queue_op(it));
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    sspq_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_data), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_value !== want.out_value)
          report_mismatch("out_value", 32'(out_data.out_value), 32'(want.out_value));
        if (out_data.out_valid !== want.out_valid)
          report_mismatch("out_valid", 32'(out_data.out_valid), 32'(want.out_valid));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.element_count !== want.element_count)
          report_mismatch("element_count", 32'(out_data.element_count),
                          32'(want.element_count));
        results_checked++;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_len runs down.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results pending",
                 quiet_cycles, pending_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic test_empty_dequeue();
    send_item(make_dequeue('1, '1));
    send_item(make_dequeue('0, '0));
    stop_sending();
  endtask

  // Extreme values and priorities, with ties at both ends of the range.
  task automatic test_order_and_ties();
    send_item(make_enqueue(16'hFFFF, 8'hFF));
    send_item(make_enqueue(16'h0000, 8'h00));
    send_item(make_enqueue(16'h1234, 8'hFF));
    send_item(make_enqueue(16'hABCD, 8'h00));
    send_item(make_enqueue(16'h5555, 8'h80));
    repeat (6) send_item(make_dequeue(16'hAAAA, 8'h55));
    stop_sending();
  endtask

  // The receiver holds off for a long stretch while enqueues keep coming, so
  // the block backs up; later the queue runs full and then is drained empty.
  task automatic test_fill_under_backpressure();
    @(posedge clk);
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < QDEPTH + 4; i++)
      send_item(make_enqueue(16'($urandom), 8'($urandom_range(3))));
    for (int i = 0; i < QDEPTH + 1; i++)
      send_item(make_dequeue(16'($urandom), 8'($urandom)));
    stop_sending();
  endtask

  // Random bursts that lean toward filling, draining or neither, with
  // priorities drawn so that ties are common in some bursts.
  task automatic test_random_mix(input int n, input int s_pct, input int r_pct);
    burst_t                              mode;
    pri_style_t                          style;
    int                                  len;
    int                                  count;
    int                                  enq_pct;
    logic [sspq_pkg::PRIORITY_WIDTH-1:0] fixed_pri;
    sspq_pkg::in_item_t                  it;
    @(posedge clk);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    count = 0;
    while (count < n) begin
      mode      = burst_t'($urandom_range(2));
      style     = pri_style_t'($urandom_range(3));
      len       = $urandom_range(40, 1);
      fixed_pri = 8'($urandom);
      case (mode)
        BURST_FILL:  enq_pct = 85;
        BURST_DRAIN: enq_pct = 15;
        default:     enq_pct = 50;
      endcase
      for (int i = 0; i < len && count < n; i++) begin
        it.opcode     = ($urandom_range(99) < enq_pct) ? sspq_pkg::OP_ENQUEUE
                                                        : sspq_pkg::OP_DEQUEUE;
        it.item_value = 16'($urandom);
        case (style)
          PRI_ANY:      it.item_priority = 8'($urandom);
          PRI_NARROW:   it.item_priority = 8'($urandom_range(3));
          PRI_EXTREMES: it.item_priority = $urandom_range(1) ? '1 : '0;
          default:      it.item_priority = fixed_pri;
        endcase
        send_item(it);
        count++;
      end
    end
    stop_sending();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    hold_len        = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 11;
    recv_idle_pct   = 72;
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    full_hits       = 0;
    empty_hits      = 0;
    values_dequeued = 0;
    shadow_fill     = 0;
    foreach (shadow_value[i]) begin
      shadow_value[i] = '0;
      shadow_prio[i]  = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_dequeue();
    test_order_and_ties();
    test_fill_under_backpressure();
    test_random_mix(500, 11, 72);
    test_random_mix(500, 72, 11);
    test_random_mix(500, 0, 0);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items, %0d results checked: %0d values dequeued,",
             items_sent, results_checked, values_dequeued);
    $display("%0d refused full, %0d refused empty; idling mixes 11/72, 72/11, none, %0d-cycle hold-off",
             full_hits, empty_hits, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: stable_sorted_priority_queue.f
+incdir+hw/rtl
hw/rtl/sspq_pkg.sv
hw/rtl/sspq_ctrl.sv
hw/rtl/sspq_dpath.sv
hw/rtl/stable_sorted_priority_queue.sv
dv/tb.sv
